>>> rtl/scgc_pkg.sv
// Shared types, constants and saturating helpers for the stiffened-gas
// conversion pipeline. No dependencies; used by every module in rtl/.
`timescale 1ns / 1ps
`default_nettype none
package scgc_pkg;

  localparam int FRAC_BITS = 32;
  localparam int WORD_W    = 64;
  localparam int DIV_STEPS = WORD_W;
  localparam int DIV_LAT   = DIV_STEPS + 2;
  localparam int MUL_LAT   = 3;

  typedef logic [WORD_W-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
  localparam word_t ONE_Q    = word_t'(1) << FRAC_BITS;
  localparam word_t ONE_LSB  = word_t'(1);

  localparam logic [1:0]  DIM_RST   = 2'd3;
  localparam logic [36:0] GAMMA_RST = 37'd6012954214;
  localparam logic [1:0]  HOLD_CYC  = 2'(MUL_LAT);

  typedef enum logic [1:0] {
    CFG_DIMENSION = 2'd0,
    CFG_GAMMA     = 2'd1,
    CFG_PINF      = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    word_t val;
    logic  sat;
  } sres_t;

  // side data riding alongside the divider lanes
  typedef struct packed {
    logic  mode;
    word_t rho;
    word_t cx;
    word_t cy;
    word_t cz;
    word_t ep;
    logic  sat;
  } dside_t;

  // side data alongside the square and momentum multipliers
  typedef struct packed {
    logic  mode;
    word_t rho;
    word_t ep;
    word_t ei;
    word_t vx;
    word_t vy;
    word_t vz;
    logic  sat;
  } mside_t;

  // side data alongside the kinetic energy multiplier
  typedef struct packed {
    logic  mode;
    word_t ep;
    word_t ei;
    word_t cx;
    word_t cy;
    word_t cz;
    logic  sat;
  } kside_t;

  // side data alongside the final gamma product
  typedef struct packed {
    logic  mode;
    word_t x;
    word_t cx;
    word_t cy;
    word_t cz;
    logic  sat;
  } tside_t;

  function automatic word_t mag(word_t a);
    return a[WORD_W-1] ? (~a + ONE_LSB) : a;
  endfunction

  function automatic sres_t sadd(word_t a, word_t b);
    word_t s;
    sres_t r;
    s = a + b;
    if (a[WORD_W-1] == b[WORD_W-1] && s[WORD_W-1] != a[WORD_W-1]) begin
      r.val = a[WORD_W-1] ? WORD_MIN : WORD_MAX;
      r.sat = 1'b1;
    end else begin
      r.val = s;
      r.sat = 1'b0;
    end
    return r;
  endfunction

  function automatic sres_t ssub(word_t a, word_t b);
    word_t s;
    sres_t r;
    s = a - b;
    if (a[WORD_W-1] != b[WORD_W-1] && s[WORD_W-1] != a[WORD_W-1]) begin
      r.val = a[WORD_W-1] ? WORD_MIN : WORD_MAX;
      r.sat = 1'b1;
    end else begin
      r.val = s;
      r.sat = 1'b0;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> rtl/scgc_mul.sv
// Three-stage fixed-point multiplier: four 32x32 partial products, wide sum
// with rounding, then shift and saturate. Depends on scgc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module scgc_mul (
  input  logic            clk,
  input  logic            en,
  input  scgc_pkg::word_t a,
  input  scgc_pkg::word_t b,
  input  logic            half_sh,
  output scgc_pkg::word_t p,
  output logic            sat
);
  import scgc_pkg::*;

  localparam int HALF = WORD_W / 2;
  localparam int PW   = 2 * WORD_W;

  word_t xa;
  word_t yb;
  logic [WORD_W-1:0] pp_r [4];
  logic neg1_r;
  logic half1_r;

  logic [PW-1:0] rnd;
  logic [PW-1:0] prod_nxt;
  logic [PW-1:0] prod_r;
  logic neg2_r;
  logic half2_r;

  logic [PW-1:0] shv;
  logic sat_nxt;
  word_t p_nxt;
  word_t p_r;
  logic sat_r;

  assign xa = mag(a);
  assign yb = mag(b);

  always_ff @(posedge clk) begin
    if (en) begin
      pp_r[0] <= {{HALF{1'b0}}, xa[HALF-1:0]} * {{HALF{1'b0}}, yb[HALF-1:0]};
      pp_r[1] <= {{HALF{1'b0}}, xa[HALF-1:0]} * {{HALF{1'b0}}, yb[WORD_W-1:HALF]};
      pp_r[2] <= {{HALF{1'b0}}, xa[WORD_W-1:HALF]} * {{HALF{1'b0}}, yb[HALF-1:0]};
      pp_r[3] <= {{HALF{1'b0}}, xa[WORD_W-1:HALF]} * {{HALF{1'b0}}, yb[WORD_W-1:HALF]};
      neg1_r  <= a[WORD_W-1] ^ b[WORD_W-1];
      half1_r <= half_sh;
    end
  end

  assign rnd = half1_r ? (PW'(1) << FRAC_BITS) : (PW'(1) << (FRAC_BITS - 1));
  assign prod_nxt = {{WORD_W{1'b0}}, pp_r[0]}
                  + {{HALF{1'b0}}, pp_r[1], {HALF{1'b0}}}
                  + {{HALF{1'b0}}, pp_r[2], {HALF{1'b0}}}
                  + {pp_r[3], {WORD_W{1'b0}}}
                  + rnd;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r  <= prod_nxt;
      neg2_r  <= neg1_r;
      half2_r <= half1_r;
    end
  end

  always_comb begin
    shv = half2_r ? (prod_r >> (FRAC_BITS + 1)) : (prod_r >> FRAC_BITS);
    sat_nxt = (|shv[PW-1:WORD_W])
            | (!neg2_r && shv[WORD_W-1])
            | (neg2_r && shv[WORD_W-1] && (|shv[WORD_W-2:0]));
    if (sat_nxt) begin
      p_nxt = neg2_r ? WORD_MIN : WORD_MAX;
    end else begin
      p_nxt = neg2_r ? (~shv[WORD_W-1:0] + ONE_LSB) : shv[WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r   <= p_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign p   = p_r;
  assign sat = sat_r;

endmodule
`default_nettype wire

>>> rtl/scgc_div.sv
// Pipelined restoring divider lane: one quotient bit per stage, rounded
// and saturated Q31.32 quotient (n << 32) / d. Depends on scgc_pkg.
`timescale 1ns / 1ps
`default_nettype none
module scgc_div (
  input  logic            clk,
  input  logic            en,
  input  scgc_pkg::word_t num,
  input  scgc_pkg::word_t den,
  output scgc_pkg::word_t quo,
  output logic            sat
);
  import scgc_pkg::*;

  localparam int LOW_W = WORD_W - FRAC_BITS;

  word_t xn;
  word_t dm;
  logic  dz;
  logic  ovf;

  word_t             rem_r [DIV_STEPS+1];
  word_t             q_r   [DIV_STEPS+1];
  word_t             dm_r  [DIV_STEPS+1];
  logic [LOW_W-1:0]  lo_r  [DIV_STEPS+1];
  logic              neg_r [DIV_STEPS+1];
  logic              sp_r  [DIV_STEPS+1];
  logic              spn_r [DIV_STEPS+1];

  assign xn  = mag(num);
  assign dm  = mag(den);
  assign dz  = (den == '0);
  // quotient of 2^64 or more cannot fit: saturate up front
  assign ovf = ({{LOW_W{1'b0}}, xn[WORD_W-1:LOW_W]} >= dm);

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= {{LOW_W{1'b0}}, xn[WORD_W-1:LOW_W]};
      q_r[0]   <= '0;
      dm_r[0]  <= dm;
      lo_r[0]  <= xn[LOW_W-1:0];
      neg_r[0] <= num[WORD_W-1] ^ den[WORD_W-1];
      sp_r[0]  <= dz | ovf;
      spn_r[0] <= dz ? num[WORD_W-1] : (num[WORD_W-1] ^ den[WORD_W-1]);
    end
  end

  for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
    word_t trial;
    logic  ge;
    assign trial = {rem_r[k][WORD_W-2:0], lo_r[k][LOW_W-1]};
    assign ge    = (trial >= dm_r[k]);
    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k+1] <= ge ? (trial - dm_r[k]) : trial;
        q_r[k+1]   <= {q_r[k][WORD_W-2:0], ge};
        dm_r[k+1]  <= dm_r[k];
        lo_r[k+1]  <= {lo_r[k][LOW_W-2:0], 1'b0};
        neg_r[k+1] <= neg_r[k];
        sp_r[k+1]  <= sp_r[k];
        spn_r[k+1] <= spn_r[k];
      end
    end
  end

  logic          up;
  logic [WORD_W:0] q65;
  logic          sat_nxt;
  logic          sgn;
  word_t         quo_nxt;
  word_t         quo_r;
  logic          sat_r;

  always_comb begin
    up  = (rem_r[DIV_STEPS] >= (dm_r[DIV_STEPS] - rem_r[DIV_STEPS]));
    q65 = {1'b0, q_r[DIV_STEPS]} + {{WORD_W{1'b0}}, up};
    sgn = sp_r[DIV_STEPS] ? spn_r[DIV_STEPS] : neg_r[DIV_STEPS];
    sat_nxt = sp_r[DIV_STEPS] | q65[WORD_W]
            | (!neg_r[DIV_STEPS] && q65[WORD_W-1])
            | (neg_r[DIV_STEPS] && q65[WORD_W-1] && (|q65[WORD_W-2:0]));
    if (sat_nxt) begin
      quo_nxt = sgn ? WORD_MIN : WORD_MAX;
    end else begin
      quo_nxt = neg_r[DIV_STEPS] ? (~q65[WORD_W-1:0] + ONE_LSB) : q65[WORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      quo_r <= quo_nxt;
      sat_r <= sat_nxt;
    end
  end

  assign quo = quo_r;
  assign sat = sat_r;

endmodule
`default_nettype wire

>>> rtl/stiffened_gas_cons_prim_convert_top.sv
// One word per cycle when not stalled by the output or by a configuration write.
// Path: input register, 66-stage divider lanes, velocity/momentum multipliers,
// sum, kinetic energy multiplier, energy stage, gamma multiplier, output register.
// A configuration write holds in_tready low while gamma * p_inf settles.
// Reset (rst_n low, synchronous): pipeline emptied, registers to reset values.
// Top level; depends on scgc_pkg, scgc_div and scgc_mul.
`timescale 1ns / 1ps
`default_nettype none
module stiffened_gas_cons_prim_convert_top (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // density, x_part, y_part, z_part, energy_or_pressure (64 bits each)
  input  logic [319:0] in_tdata,
  // mode
  input  logic [0:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // x_out, y_out, z_out, energy_or_pressure_out (64 bits each)
  output logic [255:0] out_tdata,
  // saturated
  output logic [0:0]   out_tuser,
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data
);
  import scgc_pkg::*;

  // ---------------- configuration ----------------
  logic [1:0]  dim_r;
  logic [36:0] gam_r;
  logic [62:0] pinf_r;
  logic [1:0]  hold_r;
  logic        cfg_fire;
  word_t       gm1;
  word_t       gp;
  logic        gp_sat;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dim_r  <= DIM_RST;
      gam_r  <= GAMMA_RST;
      pinf_r <= '0;
      hold_r <= '0;
    end else begin
      if (cfg_fire) begin
        case (cfg_index)
          CFG_DIMENSION: dim_r  <= cfg_data[1:0];
          CFG_GAMMA:     gam_r  <= cfg_data[36:0];
          CFG_PINF:      pinf_r <= cfg_data[62:0];
          default: ;
        endcase
      end
      if (cfg_fire) begin
        hold_r <= HOLD_CYC;
      end else if (hold_r != '0) begin
        hold_r <= hold_r - 2'd1;
      end
    end
  end

  assign gm1 = {{(WORD_W-37){1'b0}}, gam_r} - ONE_Q;

  scgc_mul u_gp (
    .clk    (clk),
    .en     (1'b1),
    .a      ({{(WORD_W-37){1'b0}}, gam_r}),
    .b      ({1'b0, pinf_r}),
    .half_sh(1'b0),
    .p      (gp),
    .sat    (gp_sat)
  );

  // ---------------- flow control ----------------
  logic [MUL_LAT-1:0] tv_r;
  logic out_valid_r;
  logic adv;
  logic in_fire;

  // advance whenever the last stage is empty or the output register frees up
  assign adv       = !tv_r[MUL_LAT-1] || !out_valid_r || out_tready;
  assign in_tready = adv && (hold_r == '0);
  assign in_fire   = in_tvalid && in_tready;

  // ---------------- input stage ----------------
  logic  mode_in;
  word_t rho_in;
  word_t rho_f;
  word_t cy_in;
  word_t cz_in;
  sres_t epg;

  assign mode_in = in_tuser[0];
  assign rho_in  = in_tdata[63:0];
  assign rho_f   = (!mode_in && (rho_in[WORD_W-1] || rho_in == '0)) ? ONE_LSB : rho_in;
  assign cy_in   = (dim_r >= 2'd2) ? in_tdata[191:128] : '0;
  assign cz_in   = (dim_r == 2'd3) ? in_tdata[255:192] : '0;
  assign epg     = sadd(in_tdata[319:256], gp);

  logic   si_v_r;
  dside_t si_r;
  word_t  si_epg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      si_v_r <= 1'b0;
    end else if (adv) begin
      si_v_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      si_r.mode <= mode_in;
      si_r.rho  <= rho_f;
      si_r.cx   <= in_tdata[127:64];
      si_r.cy   <= cy_in;
      si_r.cz   <= cz_in;
      si_r.ep   <= in_tdata[319:256];
      si_r.sat  <= mode_in & epg.sat;
      si_epg_r  <= epg.val;
    end
  end

  // ---------------- divider lanes ----------------
  word_t n0, n1, n2, d0, d1, d2;
  word_t q0, q1, q2;
  logic  qs0, qs1, qs2;

  // primitive mode uses lane 0 for (p + gamma p_inf) / (gamma - 1)
  assign n0 = si_r.mode ? si_epg_r : si_r.cx;
  assign d0 = si_r.mode ? gm1 : si_r.rho;
  assign n1 = si_r.mode ? '0 : si_r.cy;
  assign d1 = si_r.mode ? ONE_LSB : si_r.rho;
  assign n2 = si_r.mode ? '0 : si_r.cz;
  assign d2 = si_r.mode ? ONE_LSB : si_r.rho;

  scgc_div u_div0 (.clk(clk), .en(adv), .num(n0), .den(d0), .quo(q0), .sat(qs0));
  scgc_div u_div1 (.clk(clk), .en(adv), .num(n1), .den(d1), .quo(q1), .sat(qs1));
  scgc_div u_div2 (.clk(clk), .en(adv), .num(n2), .den(d2), .quo(q2), .sat(qs2));

  logic [DIV_LAT-1:0] dv_r;
  dside_t             dside_r [DIV_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_r <= '0;
    end else if (adv) begin
      dv_r <= {dv_r[DIV_LAT-2:0], si_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dside_r[0] <= si_r;
      for (int k = 1; k < DIV_LAT; k++) begin
        dside_r[k] <= dside_r[k-1];
      end
    end
  end

  // ---------------- squares and momenta ----------------
  dside_t ds;
  word_t  vx, vy, vz;
  word_t  sq0, sq1, sq2, cm0, cm1, cm2;
  logic   sqs0, sqs1, sqs2, cms0, cms1, cms2;

  assign ds = dside_r[DIV_LAT-1];
  assign vx = ds.mode ? ds.cx : q0;
  assign vy = ds.mode ? ds.cy : q1;
  assign vz = ds.mode ? ds.cz : q2;

  scgc_mul u_sq0 (.clk(clk), .en(adv), .a(vx), .b(vx), .half_sh(1'b0), .p(sq0), .sat(sqs0));
  scgc_mul u_sq1 (.clk(clk), .en(adv), .a(vy), .b(vy), .half_sh(1'b0), .p(sq1), .sat(sqs1));
  scgc_mul u_sq2 (.clk(clk), .en(adv), .a(vz), .b(vz), .half_sh(1'b0), .p(sq2), .sat(sqs2));
  scgc_mul u_cm0 (.clk(clk), .en(adv), .a(ds.rho), .b(ds.cx), .half_sh(1'b0),
                  .p(cm0), .sat(cms0));
  scgc_mul u_cm1 (.clk(clk), .en(adv), .a(ds.rho), .b(ds.cy), .half_sh(1'b0),
                  .p(cm1), .sat(cms1));
  scgc_mul u_cm2 (.clk(clk), .en(adv), .a(ds.rho), .b(ds.cz), .half_sh(1'b0),
                  .p(cm2), .sat(cms2));

  logic [MUL_LAT-1:0] mv_r;
  mside_t             mside_r [MUL_LAT];
  mside_t             ms_in;

  assign ms_in = '{mode: ds.mode, rho: ds.rho, ep: ds.ep, ei: q0,
                   vx: vx, vy: vy, vz: vz, sat: ds.sat | qs0 | qs1 | qs2};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mv_r <= '0;
    end else if (adv) begin
      mv_r <= {mv_r[MUL_LAT-2:0], dv_r[DIV_LAT-1]};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mside_r[0] <= ms_in;
      for (int k = 1; k < MUL_LAT; k++) begin
        mside_r[k] <= mside_r[k-1];
      end
    end
  end

  // ---------------- sum of squares ----------------
  mside_t ms;
  sres_t  a1, a2;
  logic   s_sat_nxt;

  assign ms = mside_r[MUL_LAT-1];
  assign a1 = sadd(sq0, sq1);
  assign a2 = sadd(a1.val, sq2);
  assign s_sat_nxt = ms.sat | sqs0 | sqs1 | sqs2 | a1.sat | a2.sat
                   | (ms.mode & (cms0 | cms1 | cms2));

  logic  s_v_r;
  logic  s_mode_r;
  word_t s_rho_r, s_ep_r, s_ei_r, s_cx_r, s_cy_r, s_cz_r, s_s2_r;
  logic  s_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_v_r <= 1'b0;
    end else if (adv) begin
      s_v_r <= mv_r[MUL_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s_mode_r <= ms.mode;
      s_rho_r  <= ms.rho;
      s_ep_r   <= ms.ep;
      s_ei_r   <= ms.ei;
      s_cx_r   <= ms.mode ? cm0 : ms.vx;
      s_cy_r   <= ms.mode ? cm1 : ms.vy;
      s_cz_r   <= ms.mode ? cm2 : ms.vz;
      s_s2_r   <= a2.val;
      s_sat_r  <= s_sat_nxt;
    end
  end

  // ---------------- kinetic energy ----------------
  word_t ke;
  logic  ke_sat;

  scgc_mul u_ke (.clk(clk), .en(adv), .a(s_rho_r), .b(s_s2_r), .half_sh(1'b1),
                 .p(ke), .sat(ke_sat));

  logic [MUL_LAT-1:0] kv_r;
  kside_t             kside_r [MUL_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      kv_r <= '0;
    end else if (adv) begin
      kv_r <= {kv_r[MUL_LAT-2:0], s_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      kside_r[0] <= '{mode: s_mode_r, ep: s_ep_r, ei: s_ei_r, cx: s_cx_r,
                      cy: s_cy_r, cz: s_cz_r, sat: s_sat_r};
      for (int k = 1; k < MUL_LAT; k++) begin
        kside_r[k] <= kside_r[k-1];
      end
    end
  end

  // ---------------- energy stage ----------------
  kside_t ks;
  sres_t  e_int;
  sres_t  e_tot;

  assign ks    = kside_r[MUL_LAT-1];
  assign e_int = ssub(ks.ep, ke);
  assign e_tot = sadd(ks.ei, ke);

  logic  e_v_r;
  logic  e_mode_r;
  word_t e_x_r, e_cx_r, e_cy_r, e_cz_r;
  logic  e_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else if (adv) begin
      e_v_r <= kv_r[MUL_LAT-1];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      e_mode_r <= ks.mode;
      e_x_r    <= ks.mode ? e_tot.val : e_int.val;
      e_cx_r   <= ks.cx;
      e_cy_r   <= ks.cy;
      e_cz_r   <= ks.cz;
      e_sat_r  <= ks.sat | ke_sat | (ks.mode ? e_tot.sat : e_int.sat);
    end
  end

  // ---------------- pressure product ----------------
  word_t tp;
  logic  tp_sat;

  scgc_mul u_tp (.clk(clk), .en(adv), .a(gm1), .b(e_x_r), .half_sh(1'b0),
                 .p(tp), .sat(tp_sat));

  tside_t tside_r [MUL_LAT];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r <= '0;
    end else if (adv) begin
      tv_r <= {tv_r[MUL_LAT-2:0], e_v_r};
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      tside_r[0] <= '{mode: e_mode_r, x: e_x_r, cx: e_cx_r, cy: e_cy_r,
                      cz: e_cz_r, sat: e_sat_r};
      for (int k = 1; k < MUL_LAT; k++) begin
        tside_r[k] <= tside_r[k-1];
      end
    end
  end

  // ---------------- output register ----------------
  tside_t ts;
  sres_t  pr;
  word_t  res_nxt;
  logic   sat_nxt;

  assign ts      = tside_r[MUL_LAT-1];
  assign pr      = ssub(tp, gp);
  assign res_nxt = ts.mode ? ts.x : pr.val;
  assign sat_nxt = ts.sat | gp_sat | (!ts.mode & (tp_sat | pr.sat));

  logic [255:0] out_data_r;
  logic         out_sat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv && tv_r[MUL_LAT-1]) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // load the finished word only when it actually leaves the pipeline
  always_ff @(posedge clk) begin
    if (adv && tv_r[MUL_LAT-1]) begin
      out_data_r <= {res_nxt, ts.cz, ts.cy, ts.cx};
      out_sat_r  <= sat_nxt;
    end
  end

  assign out_tvalid   = out_valid_r;
  assign out_tdata    = out_data_r;
  assign out_tuser[0] = out_sat_r;

endmodule
`default_nettype wire

>>> tb/sv/stiffened_gas_cons_prim_convert_chk.sv
// Result checker for the stiffened-gas conversion block: watches the input,
// output and register write channels, predicts each cell and compares.
// Depends on scgc_pkg.
`timescale 1ns / 1ps
module stiffened_gas_cons_prim_convert_chk (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  input  logic         in_tready,
  input  logic [319:0] in_tdata,
  input  logic [0:0]   in_tuser,
  input  logic         out_tvalid,
  input  logic         out_tready,
  input  logic [255:0] out_tdata,
  input  logic [0:0]   out_tuser,
  input  logic         cfg_valid,
  input  logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [63:0]  cfg_data,
  output int           fail_count,
  output int           pending
);
  import scgc_pkg::*;

  localparam logic signed [63:0] SMAX = 64'sh7fff_ffff_ffff_ffff;
  localparam logic signed [63:0] SMIN = 64'sh8000_0000_0000_0000;

  typedef struct packed {
    logic [63:0] x, y, z, ep;
    logic        sat;
  } cell_res_t;

  logic [1:0]  dim_q;
  logic [36:0] gamma_q;
  logic [62:0] pinf_q;
  cell_res_t   expected_cells[$];
  bit          clip;

  function automatic logic signed [63:0] clamp(logic signed [129:0] v);
    if (v > SMAX) begin clip = 1; return SMAX; end
    if (v < SMIN) begin clip = 1; return SMIN; end
    return v[63:0];
  endfunction

  // round half away from zero on the magnitude
  function automatic logic signed [63:0] qmul(logic signed [63:0] a, logic signed [63:0] b,
                                               int sh);
    logic [127:0] m;
    logic [129:0] r;
    m = 128'(a < 0 ? -130'(a) : 130'(a)) * 128'(b < 0 ? -130'(b) : 130'(b));
    r = (130'(m) + (130'(1) << (sh - 1))) >> sh;
    return clamp(((a < 0) != (b < 0)) ? -$signed(r) : $signed(r));
  endfunction

  function automatic logic signed [63:0] qdiv(logic signed [63:0] n, logic signed [63:0] d);
    logic [129:0] nm, dm, q, rm;
    if (d == 0) begin clip = 1; return n < 0 ? SMIN : SMAX; end
    nm = (n < 0 ? 130'(-130'(n)) : 130'(n)) << FRAC_BITS;
    dm = d < 0 ? 130'(-130'(d)) : 130'(d);
    q = nm / dm;
    rm = nm % dm;
    if (rm >= dm - rm) q = q + 1;
    return clamp(((n < 0) != (d < 0)) ? -$signed(q) : $signed(q));
  endfunction

  function automatic logic signed [63:0] qadd(logic signed [63:0] a, logic signed [63:0] b);
    return clamp(130'(a) + 130'(b));
  endfunction

  function automatic logic signed [63:0] qsub(logic signed [63:0] a, logic signed [63:0] b);
    return clamp(130'(a) - 130'(b));
  endfunction

  function automatic cell_res_t convert_cell(logic mode, logic [319:0] d);
    logic signed [63:0] rho, ep, gam, pinf, gm1, gp, v, s2, ke;
    logic signed [63:0] vel[3], comp[3];
    int nact;
    cell_res_t r;
    clip = 0;
    rho = d[63:0];
    ep = d[319:256];
    gam = 64'(gamma_q);
    pinf = 64'(pinf_q);
    gm1 = gam - (64'sd1 <<< FRAC_BITS);
    gp = qmul(gam, pinf, FRAC_BITS);
    nact = dim_q == 0 ? 1 : dim_q;
    s2 = 0;
    for (int i = 0; i < 3; i++) begin vel[i] = 0; comp[i] = 0; end
    if (!mode && rho < 1) rho = 1;
    for (int i = 0; i < nact; i++) begin
      v = d[64*(i+1) +: 64];
      if (!mode) begin
        vel[i] = qdiv(v, rho);
        comp[i] = vel[i];
      end else begin
        vel[i] = v;
        comp[i] = qmul(rho, v, FRAC_BITS);
      end
      s2 = qadd(s2, qmul(vel[i], vel[i], FRAC_BITS));
    end
    ke = qmul(rho, s2, FRAC_BITS + 1);
    if (!mode) r.ep = qsub(qmul(gm1, qsub(ep, ke), FRAC_BITS), gp);
    else r.ep = qadd(qdiv(qadd(ep, gp), gm1), ke);
    r.x = comp[0];
    r.y = comp[1];
    r.z = comp[2];
    r.sat = clip;
    return r;
  endfunction

  assign pending = expected_cells.size();

  always @(posedge clk) begin
    cell_res_t got, want;
    if (!rst_n) begin
      dim_q <= DIM_RST;
      gamma_q <= GAMMA_RST;
      pinf_q <= '0;
      fail_count <= 0;
      expected_cells.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_DIMENSION: dim_q <= cfg_data[1:0];
          CFG_GAMMA:     gamma_q <= cfg_data[36:0];
          CFG_PINF:      pinf_q <= cfg_data[62:0];
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        expected_cells.push_back(convert_cell(in_tuser[0], in_tdata));
      if (out_tvalid && out_tready) begin
        got = {out_tdata[63:0], out_tdata[127:64], out_tdata[191:128],
               out_tdata[255:192], out_tuser[0]};
        if (expected_cells.size() == 0) begin
          $display("%0t: unexpected word %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_cells.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected x=%h y=%h z=%h e=%h sat=%b", $time,
                     want.x, want.y, want.z, want.ep, want.sat);
            $display("%0t:          actual   x=%h y=%h z=%h e=%h sat=%b", $time,
                     got.x, got.y, got.z, got.ep, got.sat);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end
endmodule

>>> tb/sv/tb.sv
// Top of the conversion block testbench: clock, reset, register writes and cell
// stimulus with idling phases; verdict from the checker. Depends on scgc_pkg.
`timescale 1ns / 1ps
module tb;
  import scgc_pkg::*;

  localparam int WATCHDOG = 20000;

  logic         clk = 0;
  logic         rst_n = 0;
  logic         in_tvalid = 0, in_tready;
  logic [319:0] in_tdata = '0;
  logic [0:0]   in_tuser = '0;
  logic         out_tvalid, out_tready = 0;
  logic [255:0] out_tdata;
  logic [0:0]   out_tuser;
  logic         cfg_valid = 0, cfg_ready;
  logic [1:0]   cfg_index = '0;
  logic [63:0]  cfg_data = '0;
  int           fail_count, pending;
  int           send_idle_pct = 0, recv_stall_pct = 0;
  int           hold_off = 0;
  int           idle_cycles = 0;

  stiffened_gas_cons_prim_convert_top dut (.*);
  stiffened_gas_cons_prim_convert_chk chk (.*);

  always begin #5 clk = 1; #5 clk = 0; end

  // receiver: random stall, plus a long hold-off when asked
  always @(posedge clk) begin
    if (hold_off > 0) begin
      hold_off <= hold_off - 1;
      out_tready <= 0;
    end else out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  function automatic logic [63:0] rand_word();
    case ($urandom_range(5))
      0: return {$urandom, $urandom};
      1: return 64'(signed'({$urandom_range(2047)})) - 1024 <<< 32;
      2: return 64'($urandom_range(1 << 20)) << $urandom_range(40);
      3: return {{32{1'b0}}, $urandom} + (64'($urandom_range(15)) << 32);
      4: return -(64'($urandom) << $urandom_range(24));
      default: return $urandom_range(3) == 0 ? 64'h8000_0000_0000_0000 :
                      64'h7fff_ffff_ffff_ffff;
    endcase
  endfunction

  // drop valid so that it is seen low before the next write raises it again
  task automatic write_reg(cfg_idx_t idx, logic [63:0] val);
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    @(posedge clk);
  endtask

  task automatic send_cell(logic mode, logic [63:0] rho, logic [63:0] x, logic [63:0] y,
                           logic [63:0] z, logic [63:0] ep);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 0;
      @(posedge clk);
    end
    in_tvalid <= 1;
    in_tuser <= mode;
    in_tdata <= {ep, z, y, x, rho};
    do @(posedge clk); while (!in_tready);
  endtask

  task automatic send_random(int n);
    logic [63:0] rho;
    repeat (n) begin
      rho = $urandom_range(3) == 0 ? rand_word() : 64'($urandom_range(1 << 12)) << 28;
      send_cell($urandom_range(1), rho, rand_word(), rand_word(), rand_word(), rand_word());
    end
    in_tvalid <= 0;
  endtask

  // let the pipeline empty before touching the registers
  task automatic drain();
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    // directed: defaults first, then extremes of the fields
    send_cell(0, 64'd0, 64'd1 << 32, -(64'd1 << 32), 64'd5, 64'd10 << 32);
    send_cell(0, -(64'd3), 64'h7fff_ffff_ffff_ffff, 64'h8000_0000_0000_0000, 0, 0);
    send_cell(0, 64'h7fff_ffff_ffff_ffff, 64'hffff_ffff_ffff_ffff, 0, 64'h7fff_ffff_ffff_ffff,
              64'h8000_0000_0000_0000);
    send_cell(1, 64'd2 << 32, 64'd3 << 32, 64'd1 << 31, -(64'd1 << 32), 64'd1 << 32);
    send_cell(1, 64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff, 64'h7fff_ffff_ffff_ffff,
              64'h8000_0000_0000_0000, 64'h7fff_ffff_ffff_ffff);
    send_cell(1, 0, 0, 0, 0, 0);
    send_cell(0, 64'd1, 64'd1, 64'd1, 64'd1, 64'hffff_ffff_ffff_ffff);
    in_tvalid <= 0;
    drain();
    // gamma equal to one: divide by zero in mode 1
    write_reg(CFG_GAMMA, 64'd4294967296);
    write_reg(CFG_PINF, 64'd1 << 32);
    send_cell(1, 64'd1 << 32, 64'd1 << 32, 0, 0, 64'd5 << 32);
    send_cell(1, 64'd1 << 32, 0, 0, 0, -(64'd5 << 32));
    send_cell(0, 64'd1 << 32, 64'd1 << 32, 0, 0, 64'd5 << 32);
    in_tvalid <= 0;
    drain();
    // gamma below one, dimension zero
    write_reg(CFG_GAMMA, 64'd1 << 31);
    write_reg(CFG_DIMENSION, 64'd0);
    send_cell(0, 64'd2 << 32, 64'd4 << 32, 64'd4 << 32, 64'd4 << 32, 64'd9 << 32);
    send_cell(1, 64'd2 << 32, 64'd4 << 32, 64'd4 << 32, 64'd4 << 32, 64'd9 << 32);
    in_tvalid <= 0;
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_reg(CFG_DIMENSION, 64'(ph % 3 + 1));
      case (ph % 4)
        0: write_reg(CFG_GAMMA, 64'd4294967297);
        1: write_reg(CFG_GAMMA, 64'd68719476736);
        default: write_reg(CFG_GAMMA, 64'd4294967297 + {$urandom_range(15), $urandom});
      endcase
      case (ph % 3)
        0: write_reg(CFG_PINF, 64'd0);
        1: write_reg(CFG_PINF, 64'd4611686018427387904);
        default: write_reg(CFG_PINF, 64'($urandom) << $urandom_range(32));
      endcase
      send_idle_pct  = (ph % 4 == 1 || ph % 4 == 3) ? (ph % 4 == 3 ? 19 : 58) : 0;
      recv_stall_pct = (ph % 4 == 2 || ph % 4 == 3) ? (ph % 4 == 3 ? 19 : 58) : 0;
      if (ph == 4) hold_off = 400;
      send_random(80);
      drain();
    end
    recv_stall_pct = 0;
    if (fail_count == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
